// ----- sv/aip_pkg.sv -----
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants for the ascii integer parser
// Item layouts, configuration bundle, status and parse-phase codes, digit map.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] NO_DIGIT    = 8'hFF;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SELECT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_PLUS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_LZERO  = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_SIGN      = 3'd2,
    ST_LEAD_ZERO = 3'd3,
    ST_BAD_DIGIT = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CS_NONE  = 2'd0,
    CS_SIGN  = 2'd1,
    CS_DIGIT = 2'd2
  } chars_seen_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [63:0] value;
  } out_item_t;

  typedef struct packed {
    logic [5:0] radix;
    logic       signed_mode;
    logic [1:0] width_select;
    logic       allow_plus;
    logic       allow_leading_zero;
  } cfg_t;

  // item handed from the input register to the parse core
  typedef struct packed {
    logic     fire;
    in_item_t item;
  } step_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h61 + 8'd10;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = c - 8'h41 + 8'd10;
    end else begin
      r = NO_DIGIT;
    end
    return r;
  endfunction

endpackage

// ----- sv/aip_stream_if.sv -----
// ----------------------------------------------------------------------------
// aip_stream_if: valid/ready channel
// Carries one payload item per handshake; source and sink views.
// ----------------------------------------------------------------------------
interface aip_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/aip_in_stage.sv -----
// ----------------------------------------------------------------------------
// aip_in_stage: input register
// Holds one character item and releases it to the parse core when the
// result side can take whatever the item produces.
// ----------------------------------------------------------------------------
module aip_in_stage
  import aip_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  aip_stream_if.sink   in_s,
  input  logic         out_free_i,
  output step_t        step_o
);

  logic     valid_q, valid_d;
  in_item_t item_q, item_d;
  logic     advance;
  logic     take;

  // only a last item needs room in the output register
  assign advance   = valid_q && (!item_q.last || out_free_i);
  assign in_s.ready = !valid_q || advance;
  assign take      = in_s.valid && in_s.ready;

  always_comb begin
    valid_d = take ? 1'b1 : (advance ? 1'b0 : valid_q);
    item_d  = take ? in_s.payload : item_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign step_o.fire = advance;
  assign step_o.item = item_q;

endmodule

// ----- sv/aip_core.sv -----
// ----------------------------------------------------------------------------
// aip_core: parse state and per-character update
// Running magnitude, sign, leading-zero and sticky error state; one
// multiply-add and limit compare per character, result built on last.
// ----------------------------------------------------------------------------
module aip_core
  import aip_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  step_t     step_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  localparam int unsigned LimW  = ACC_WIDTH + 1;
  localparam int unsigned ProdW = ACC_WIDTH + 7;
  localparam logic [6:0]  AccW  = 7'(ACC_WIDTH);

  logic [ACC_WIDTH-1:0] acc_q, acc_d;
  chars_seen_e          cs_q, cs_d;
  logic                 neg_q, neg_d;
  logic                 fz_q, fz_d;
  status_e              err_q, err_d;

  logic [7:0]       ch;
  logic [7:0]       dval;
  logic [6:0]       base_w;
  logic [6:0]       tgt_w;
  logic [LimW-1:0]  lim;
  logic [ProdW-1:0] prod;
  logic             over;
  status_e          status;
  logic [63:0]      mag64;

  always_comb begin
    ch     = step_i.item.ch;
    dval   = digit_value(ch);
    base_w = 7'd8 << cfg_i.width_select;
    tgt_w  = (base_w > AccW) ? AccW : base_w;
    if (cfg_i.signed_mode) begin
      lim = (LimW'(1) << 7'(tgt_w - 7'd1)) - (neg_q ? LimW'(0) : LimW'(1));
    end else begin
      lim = (LimW'(1) << tgt_w) - LimW'(1);
    end
    // acc*r + d > lim is the same test as acc > (lim - d) / r
    prod = ProdW'(acc_q) * ProdW'(cfg_i.radix) + ProdW'(dval);
    over = prod > ProdW'(lim);
  end

  always_comb begin
    acc_d = acc_q;
    cs_d  = cs_q;
    neg_d = neg_q;
    fz_d  = fz_q;
    err_d = err_q;

    if (step_i.fire && step_i.item.has_char && err_q == ST_OK) begin
      if (cs_q == CS_NONE && ch == ASCII_PLUS) begin
        if (!cfg_i.allow_plus) err_d = ST_SIGN;
        else cs_d = CS_SIGN;
      end else if (cs_q == CS_NONE && ch == ASCII_MINUS) begin
        if (!cfg_i.signed_mode) begin
          err_d = ST_SIGN;
        end else begin
          neg_d = 1'b1;
          cs_d  = CS_SIGN;
        end
      end else if (cs_q == CS_DIGIT && fz_q && !cfg_i.allow_leading_zero) begin
        err_d = ST_LEAD_ZERO;
      end else begin
        if (cs_q != CS_DIGIT) begin
          fz_d = (ch == ASCII_ZERO);
          cs_d = CS_DIGIT;
        end
        if (dval >= {2'b00, cfg_i.radix}) begin
          err_d = ST_BAD_DIGIT;
        end else if (over) begin
          err_d = ST_OVERFLOW;
        end else begin
          acc_d = prod[ACC_WIDTH-1:0];
        end
      end
    end

    // result from the state after this character
    status = err_d;
    if (status == ST_OK && cs_d != CS_DIGIT) status = ST_EMPTY;
    mag64        = 64'(acc_d);
    res_o.ok     = (status == ST_OK);
    res_o.status = status;
    if (status != ST_OK) begin
      res_o.value = 64'd0;
    end else if (cfg_i.signed_mode && neg_d) begin
      res_o.value = 64'd0 - mag64;
    end else begin
      res_o.value = mag64;
    end
    res_valid_o = step_i.fire && step_i.item.last;

    if (res_valid_o) begin
      acc_d = '0;
      cs_d  = CS_NONE;
      neg_d = 1'b0;
      fz_d  = 1'b0;
      err_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cs_q  <= CS_NONE;
      neg_q <= 1'b0;
      fz_q  <= 1'b0;
      err_q <= ST_OK;
    end else begin
      acc_q <= acc_d;
      cs_q  <= cs_d;
      neg_q <= neg_d;
      fz_q  <= fz_d;
      err_q <= err_d;
    end
  end

endmodule

// ----- sv/aip_out_stage.sv -----
// ----------------------------------------------------------------------------
// aip_out_stage: result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module aip_out_stage
  import aip_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  out_item_t     data_i,
  output logic          free_o,
  aip_stream_if.source  out_s
);

  logic      valid_q, valid_d;
  out_item_t data_q, data_d;

  assign free_o = !valid_q || out_s.ready;

  always_comb begin
    valid_d = load_i || (valid_q && !out_s.ready);
    data_d  = load_i ? data_i : data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_s.valid   = valid_q;
  assign out_s.payload = data_q;

endmodule

// ----- sv/ascii_integer_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_integer_parser: radix text to integer converter
// Parses a signed or unsigned integer one character per item, checks range
// against an 8/16/32/64-bit target and gives one result per string.
// ----------------------------------------------------------------------------
//   port        dir   content
//   in_i        in    ch, has_char, last
//   out_o       out   ok, status, value (one item per string, on last)
//   cfg_*_i     in    radix, signed_mode, width_select, allow_plus,
//                     allow_leading_zero
//
// one character item per cycle while the result side does not stall; a result is
// registered after its last item is accepted (input register, then result register)
// the per-character multiply-add and limit compare sit between the two
// registers; the state loop closes on that single step
// input stalls only while a last item waits on a full, stalled result register
// reset clears the parse state and loads the configuration defaults
module ascii_integer_parser
  import aip_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  aip_stream_if.sink            in_i,
  aip_stream_if.source          out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  step_t     step;
  logic      out_free;
  logic      res_valid;
  out_item_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIX:        cfg_d.radix              = cfg_data_i;
        REG_SIGNED_MODE:  cfg_d.signed_mode        = cfg_data_i[0];
        REG_WIDTH_SELECT: cfg_d.width_select       = cfg_data_i[1:0];
        REG_ALLOW_PLUS:   cfg_d.allow_plus         = cfg_data_i[0];
        REG_ALLOW_LZERO:  cfg_d.allow_leading_zero = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix              <= 6'd10;
      cfg_q.signed_mode        <= 1'b0;
      cfg_q.width_select       <= 2'd3;
      cfg_q.allow_plus         <= 1'b0;
      cfg_q.allow_leading_zero <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  aip_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_i),
    .out_free_i (out_free),
    .step_o     (step)
  );

  aip_core #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  aip_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .data_i (res),
    .free_o (out_free),
    .out_s  (out_o)
  );

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without a pending result");

  // a result is only produced when the result register has room
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result produced into a full result register");

  // ok flag agrees with status, failed parses carry zero
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.payload.ok == (out_o.payload.status == ST_OK)) &&
                     (out_o.payload.ok || out_o.payload.value == 64'd0)))
    else $error("result ok flag, status and value disagree");

endmodule
